@@ rtl/csv_byte_tokenizer_defines.svh @@
// assertion macros used by the checker
`ifndef CSV_BYTE_TOKENIZER_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_DEFINES_SVH

// checked only while out of reset
`define CBT_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("csv tokenizer check failed");

// checked at every edge, reset included
`define CBT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("csv tokenizer reset check failed");

`endif

@@ rtl/cbt_pkg.sv @@
package cbt_pkg;

    localparam int CBT_MAX_COLUMNS = 1024;
    localparam int COL_W           = 10;
    localparam int MAX_EV          = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_FIELD   = 2'd1,
        KIND_RECORD  = 2'd2
    } t_kind;

    typedef enum logic [5:0] {
        PH_REC_START = 6'b000001,
        PH_FRESH     = 6'b000010,
        PH_UNQ       = 6'b000100,
        PH_QUOTED    = 6'b001000,
        PH_QSEEN     = 6'b010000,
        PH_AFTER     = 6'b100000
    } t_phase;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [COL_W-1:0] col;
        logic             hdr;
        logic             last;
    } t_event;

    // all events caused by one input word
    typedef struct packed {
        logic [1:0]          cnt;
        t_event [MAX_EV-1:0] ev;
    } t_bundle;

endpackage

@@ rtl/cbt_parse.sv @@
module cbt_parse
    import cbt_pkg::*;
#(
    parameter int MAX_COLUMNS = CBT_MAX_COLUMNS,
    localparam int CW = $clog2(MAX_COLUMNS + 1)
) (
    input  logic [7:0]    i_byte,
    input  logic          i_eoi,
    input  logic          i_header_mode,
    input  t_phase        i_phase,
    input  logic [CW-1:0] i_fc,
    input  logic [CW-1:0] i_hc,
    input  logic          i_hp,
    output t_phase        o_phase,
    output logic [CW-1:0] o_fc,
    output logic [CW-1:0] o_hc,
    output logic          o_hp,
    output t_bundle       o_bundle
);

    localparam logic [CW-1:0] MAX_C  = CW'(MAX_COLUMNS);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_COLUMNS - 1);

    function automatic logic [COL_W-1:0] col_of(input logic [CW-1:0] fc);
        logic [CW-1:0]       s;
        logic [CW+COL_W-1:0] w;
        s = (fc > LAST_C) ? LAST_C : fc;
        w = {{COL_W{1'b0}}, s};
        return w[COL_W-1:0];
    endfunction

    function automatic t_event mk_ev(input t_kind k, input logic [7:0] d,
                                     input logic [COL_W-1:0] c, input logic h);
        t_event e;
        e.kind = k;
        e.data = d;
        e.col  = c;
        e.hdr  = h;
        e.last = 1'b0;
        return e;
    endfunction

    always_comb begin
        logic          term, is_quote, is_comma;
        logic          ce, fe, re, nxt, blank, inh, supp;
        logic [7:0]    cb;
        logic [CW-1:0] fc0;
        logic [1:0]    n;

        o_phase  = i_phase;
        o_fc     = i_fc;
        o_hc     = i_hc;
        o_hp     = i_hp;
        o_bundle = '0;

        term     = (i_byte == CH_CR) || (i_byte == CH_LF);
        is_quote = (i_byte == CH_QUOTE);
        is_comma = (i_byte == CH_COMMA);
        ce       = 1'b0;
        fe       = 1'b0;
        re       = 1'b0;
        nxt      = 1'b0;
        blank    = 1'b0;
        cb       = i_byte;
        n        = 2'd0;
        fc0      = (i_phase == PH_REC_START) ? '0 : i_fc;

        case (i_phase)
            PH_FRESH, PH_UNQ: begin
                if (term) begin
                    fe = 1'b1;
                    re = 1'b1;
                end else if (is_comma) begin
                    fe      = 1'b1;
                    nxt     = 1'b1;
                    o_phase = PH_FRESH;
                end else if (is_quote && i_phase == PH_FRESH) begin
                    o_phase = PH_QUOTED;
                end else begin
                    ce      = 1'b1;
                    o_phase = PH_UNQ;
                end
            end
            PH_QUOTED: begin
                if (is_quote) begin
                    o_phase = PH_QSEEN;
                end else begin
                    ce = 1'b1;
                end
            end
            PH_QSEEN, PH_AFTER: begin
                if (is_quote && i_phase == PH_QSEEN) begin
                    // doubled quote inside a quoted field
                    ce      = 1'b1;
                    cb      = CH_QUOTE;
                    o_phase = PH_QUOTED;
                end else if (term) begin
                    fe = 1'b1;
                    re = 1'b1;
                end else if (is_comma) begin
                    fe      = 1'b1;
                    nxt     = 1'b1;
                    o_phase = PH_FRESH;
                end else begin
                    o_phase = PH_AFTER;
                end
            end
            default: begin
                o_phase = PH_REC_START;
                o_fc    = '0;
                if (term) begin
                    // blank record: only a blank header reports anything
                    if (i_header_mode && i_hp) begin
                        re    = 1'b1;
                        blank = 1'b1;
                    end
                end else if (is_comma) begin
                    fe      = 1'b1;
                    nxt     = 1'b1;
                    o_phase = PH_FRESH;
                end else if (is_quote) begin
                    o_phase = PH_QUOTED;
                end else begin
                    ce      = 1'b1;
                    o_phase = PH_UNQ;
                end
            end
        endcase

        inh  = i_header_mode && i_hp;
        supp = i_header_mode && !i_hp && (fc0 >= i_hc);

        if ((ce || fe) && !supp) begin
            o_bundle.ev[n] = mk_ev(ce ? KIND_CONTENT : KIND_FIELD, ce ? cb : 8'd0,
                                   col_of(fc0), inh);
            n = n + 2'd1;
        end
        if (re) begin
            o_bundle.ev[n] = mk_ev(KIND_RECORD, 8'd0, col_of(fc0), inh);
            n = n + 2'd1;
            if (inh) begin
                if (blank) begin
                    o_hc = '0;
                end else begin
                    o_hc = (fc0 < MAX_C) ? fc0 + CW'(1) : MAX_C;
                end
                o_hp = 1'b0;
            end
            o_fc    = '0;
            o_phase = PH_REC_START;
        end
        if (nxt) begin
            o_fc = (fc0 < MAX_C) ? fc0 + CW'(1) : fc0;
        end

        // close an open record at the end of the document
        if (i_eoi) begin
            if (o_phase != PH_REC_START) begin
                if (!(i_header_mode && !o_hp && (o_fc >= o_hc))) begin
                    o_bundle.ev[n] = mk_ev(KIND_FIELD, 8'd0, col_of(o_fc),
                                           i_header_mode && o_hp);
                    n = n + 2'd1;
                end
                o_bundle.ev[n] = mk_ev(KIND_RECORD, 8'd0, col_of(o_fc),
                                       i_header_mode && o_hp);
                n = n + 2'd1;
            end
            o_phase = PH_REC_START;
            o_fc    = '0;
            o_hc    = '0;
            o_hp    = 1'b1;
        end

        o_bundle.cnt = n;
        for (int i = 0; i < MAX_EV; i++) begin
            o_bundle.ev[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
        end
    end

endmodule

@@ rtl/cbt_evq.sv @@
module cbt_evq
    import cbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    output logic    o_tvalid,
    input  logic    i_tready,
    output t_event  o_event
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_idx, n_idx;
    t_bundle       cur;
    logic          pop_ev, pop_b;

    assign cur      = r_mem[r_rd];
    assign o_tvalid = (r_cnt != '0);
    assign o_full   = (r_cnt == NW'(DEPTH));
    assign o_event  = cur.ev[r_idx];
    assign pop_ev   = o_tvalid && i_tready;
    assign pop_b    = pop_ev && (r_idx == cur.cnt - 2'd1);

    always_comb begin
        n_wr  = i_push ? r_wr + PW'(1) : r_wr;
        n_rd  = pop_b ? r_rd + PW'(1) : r_rd;
        n_cnt = r_cnt + NW'(i_push) - NW'(pop_b);
        if (pop_b) begin
            n_idx = 2'd0;
        end else if (pop_ev) begin
            n_idx = r_idx + 2'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_idx <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

endmodule

@@ rtl/csv_byte_tokenizer.sv @@
// channel  | dir | tdata                 | tuser              | tlast
// s_axis   | in  | [7:0] text_byte       | -                  | end_of_input
// m_axis   | out | [7:0] content_byte,   | [1:0] event_kind,  | last_of_run
//          |     | [17:8] column_index   | [2] from_header    |
// cfg      | in  | i_cfg_wdata: header_mode, written when i_cfg_we is high
//
// one byte is accepted per cycle unless the event queue is full; it is held in
// the input register, parsed in one pass into a bundle of zero to three events.
// the event queue holds two bundles and sends one event per cycle while
// m_axis_tready is high, so the output rate bounds the sustained input rate.
// synchronous active-low reset clears the parser state and the queue.
// a stall on m_axis only stops input once both queue entries are taken.
module csv_byte_tokenizer
    import cbt_pkg::*;
#(
    parameter int MAX_COLUMNS = CBT_MAX_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // content_byte, column_index, zero pad
    output logic [2:0]  m_axis_tuser,   // event_kind, from_header
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);

    logic          r_hm;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_eoi;
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_fc, n_fc, r_hc, n_hc;
    logic          r_hp, n_hp;
    t_bundle       bundle;
    t_event        ev;
    logic          q_full, fire;

    assign fire          = r_in_valid && !q_full;
    assign s_axis_tready = !r_in_valid || fire;

    cbt_parse #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_parse (
        .i_byte        (r_in_byte),
        .i_eoi         (r_in_eoi),
        .i_header_mode (r_hm),
        .i_phase       (r_phase),
        .i_fc          (r_fc),
        .i_hc          (r_hc),
        .i_hp          (r_hp),
        .o_phase       (n_phase),
        .o_fc          (n_fc),
        .o_hc          (n_hc),
        .o_hp          (n_hp),
        .o_bundle      (bundle)
    );

    cbt_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire && bundle.cnt != 2'd0),
        .i_bundle (bundle),
        .o_full   (q_full),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_event  (ev)
    );

    assign m_axis_tdata = {6'd0, ev.col, ev.data};
    assign m_axis_tuser = {ev.hdr, ev.kind};
    assign m_axis_tlast = ev.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hm       <= 1'b0;
            r_in_valid <= 1'b0;
            r_phase    <= PH_REC_START;
            r_fc       <= '0;
            r_hc       <= '0;
            r_hp       <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_hm <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_fc    <= n_fc;
                r_hc    <= n_hc;
                r_hp    <= n_hp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tlast;
        end
    end

endmodule

@@ rtl/cbt_sva.sv @@
`include "csv_byte_tokenizer_defines.svh"

module cbt_sva
    import cbt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled output word holds
    `CBT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // a record end always closes the run of its byte
    `CBT_ASSERT(a_rec_last, m_axis_tvalid && m_axis_tuser[1:0] == KIND_RECORD |-> m_axis_tlast)

    // only content words carry a byte
    `CBT_ASSERT(a_zero_byte, m_axis_tvalid && m_axis_tuser[1:0] != KIND_CONTENT |-> m_axis_tdata[7:0] == 8'd0)

    // after a reset cycle the output is empty and input is open
    `CBT_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_axis_tvalid && s_axis_tready)

endmodule

bind csv_byte_tokenizer cbt_sva u_sva (.*);
